// ----- hw/rtl/obb_overlap_separating_axis_macros.svh -----
// Assertion helpers for the box overlap block
`ifndef OBB_OVERLAP_SEPARATING_AXIS_MACROS_SVH
`define OBB_OVERLAP_SEPARATING_AXIS_MACROS_SVH
// Check an implication on every clock edge outside reset
`define OBB_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
// Check a next-cycle implication outside reset
`define OBB_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

// ----- hw/rtl/obb_pkg.sv -----
package obb_pkg;
  localparam int CompBits = 21;
  localparam int FracBits = 8;
  localparam int VecBits = 63;
  localparam int NumAxes = 15;
  localparam int NumRegs = 5;
  localparam int IdxBits = 3;
  localparam int TdataBits = 320;
  // Center differences need one bit more than a component
  localparam int DiffBits = CompBits + 1;
  // Cross components need 2*CompBits+1, products with them 3*CompBits+3
  localparam int CrossBits = 2 * CompBits + 2;
  localparam int DotBits = CrossBits + CompBits + 3;
  localparam int RadBits = DotBits + CompBits + 4;
  // Projections are weighted in a low and a high half
  localparam int LoBits = 32;
  localparam int HiBits = DotBits - LoBits;

  localparam logic [IdxBits-1:0] RegRefCenter  = 3'd0;
  localparam logic [IdxBits-1:0] RegRefExtents = 3'd1;
  localparam logic [IdxBits-1:0] RegRefAxis0   = 3'd2;
  localparam logic [IdxBits-1:0] RegRefAxis1   = 3'd3;
  localparam logic [IdxBits-1:0] RegRefAxis2   = 3'd4;

  // Which candidate axis a cell tests
  typedef enum logic [1:0] {
    AxisFaceRef,
    AxisFaceBox,
    AxisCross
  } axis_kind_t;

  typedef logic signed [CompBits-1:0] comp_t;
  typedef comp_t [2:0] vec_t;
  typedef logic signed [CrossBits-1:0] cross_t;
  typedef cross_t [2:0] axis_t;

  // One box in unpacked form
  typedef struct packed {
    vec_t center;
    vec_t ext;
    vec_t [2:0] rows;
  } box_t;

  // Data handed from cell to cell: both boxes plus running verdict
  typedef struct packed {
    logic valid;
    logic apart;
    box_t a;
    box_t b;
  } token_t;

  function automatic vec_t unpack_vec(logic [VecBits-1:0] p);
    vec_t v;
    v[0] = p[CompBits-1:0];
    v[1] = p[2*CompBits-1:CompBits];
    v[2] = p[3*CompBits-1:2*CompBits];
    return v;
  endfunction
endpackage

// ----- hw/rtl/obb_cell.sv -----
// One axis test stage: axis and products, then projections, then the low
// half of the radius, then the high half and the compare.
// Four register levels so no path has more than one multiply.
module obb_cell
  import obb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       stall,
  input  axis_kind_t kind,
  input  logic [1:0] row_a,
  input  logic [1:0] row_b,
  input  token_t     tok_in,
  output token_t     tok_out
);
  token_t t1, t2, t3, tok_next;
  axis_t ax1;
  logic skip1, skip2, skip3;
  logic signed [DotBits-1:0] dd2, pa2 [3], pb2 [3];
  logic signed [DotBits-1:0] dd3;
  logic signed [RadBits-1:0] rad_lo3;
  logic [HiBits-1:0] ha3 [3], hb3 [3];
  axis_t ax_c;
  vec_t pa_row, pb_row;
  logic signed [DiffBits-1:0] diff [3];
  logic signed [DotBits-1:0] dd_c, pa_c [3], pb_c [3];
  logic signed [RadBits-1:0] rad_lo_c, rad_hi, rad, scaled_dd;
  logic sep;

  // Pick the candidate axis
  always_comb begin
    pa_row = tok_in.a.rows[row_a];
    pb_row = tok_in.b.rows[row_b];
    ax_c = '0;
    case (kind)
      AxisFaceRef: begin
        for (int k = 0; k < 3; k++) ax_c[k] = CrossBits'(pa_row[k]);
      end
      AxisFaceBox: begin
        for (int k = 0; k < 3; k++) ax_c[k] = CrossBits'(pb_row[k]);
      end
      AxisCross: begin
        ax_c[0] = CrossBits'(pb_row[1]) * CrossBits'(pa_row[2])
                - CrossBits'(pb_row[2]) * CrossBits'(pa_row[1]);
        ax_c[1] = CrossBits'(pb_row[2]) * CrossBits'(pa_row[0])
                - CrossBits'(pb_row[0]) * CrossBits'(pa_row[2]);
        ax_c[2] = CrossBits'(pb_row[0]) * CrossBits'(pa_row[1])
                - CrossBits'(pb_row[1]) * CrossBits'(pa_row[0]);
      end
      default: ax_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.valid <= 1'b0;
    end else if (!stall) begin
      t1 <= tok_in;
      ax1 <= ax_c;
      skip1 <= (kind == AxisCross) && (ax_c == '0);
    end
  end

  // Project difference and all six rows onto the axis
  always_comb begin
    for (int k = 0; k < 3; k++)
      diff[k] = DiffBits'(t1.b.center[k]) - DiffBits'(t1.a.center[k]);
    dd_c = '0;
    for (int k = 0; k < 3; k++) begin
      dd_c = dd_c + DotBits'(diff[k]) * DotBits'(ax1[k]);
    end
    for (int r = 0; r < 3; r++) begin
      pa_c[r] = '0;
      pb_c[r] = '0;
      for (int k = 0; k < 3; k++) begin
        pa_c[r] = pa_c[r] + DotBits'(t1.a.rows[r][k]) * DotBits'(ax1[k]);
        pb_c[r] = pb_c[r] + DotBits'(t1.b.rows[r][k]) * DotBits'(ax1[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t2.valid <= 1'b0;
    end else if (!stall) begin
      t2 <= t1;
      skip2 <= skip1;
      dd2 <= (dd_c < 0) ? -dd_c : dd_c;
      for (int r = 0; r < 3; r++) begin
        pa2[r] <= (pa_c[r] < 0) ? -pa_c[r] : pa_c[r];
        pb2[r] <= (pb_c[r] < 0) ? -pb_c[r] : pb_c[r];
      end
    end
  end

  // Weight the low halves of the projections by the extents
  always_comb begin
    rad_lo_c = '0;
    for (int r = 0; r < 3; r++) begin
      rad_lo_c = rad_lo_c
               + RadBits'($signed({1'b0, pa2[r][LoBits-1:0]})) * RadBits'(t2.a.ext[r])
               + RadBits'($signed({1'b0, pb2[r][LoBits-1:0]})) * RadBits'(t2.b.ext[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t3.valid <= 1'b0;
    end else if (!stall) begin
      t3 <= t2;
      skip3 <= skip2;
      dd3 <= dd2;
      rad_lo3 <= rad_lo_c;
      for (int r = 0; r < 3; r++) begin
        ha3[r] <= pa2[r][DotBits-1:LoBits];
        hb3[r] <= pb2[r][DotBits-1:LoBits];
      end
    end
  end

  // Add the high halves and compare
  always_comb begin
    rad_hi = '0;
    for (int r = 0; r < 3; r++) begin
      rad_hi = rad_hi
             + RadBits'($signed({1'b0, ha3[r]})) * RadBits'(t3.a.ext[r])
             + RadBits'($signed({1'b0, hb3[r]})) * RadBits'(t3.b.ext[r]);
    end
    rad = rad_lo3 + (rad_hi <<< LoBits);
    scaled_dd = RadBits'(dd3) <<< FracBits;
    sep = !skip3 && (scaled_dd > rad);
    tok_next = t3;
    tok_next.apart = t3.apart | sep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (!stall) begin
      tok_out <= tok_next;
    end
  end
endmodule

// ----- hw/rtl/obb_overlap_separating_axis.sv -----
// Oriented box overlap by separating axis test.
// Configure the reference box through cfg_we/cfg_index/cfg_data while idle
// (index 0 center, 1 extents, 2..4 axis rows). Stream tested boxes on the
// s_axis channel; each request returns one byte on m_axis, bit 0: 1 = overlap.
// A row of 15 cells, one per candidate axis, each four stages deep, passes
// the boxes and the running verdict along through 60 register levels.
// Throughput one box per cycle while the receiver does not stall.
// A stalled receiver freezes the whole row; the final cell is the output
// register, so s_axis_tready is high whenever the output is free or taken.
// Reset clears all valid bits and the reference registers to zero.
module obb_overlap_separating_axis
  import obb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [IdxBits-1:0]   cfg_index,
  input  logic [VecBits-1:0]   cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // box_center, box_extents, box_axis_first, box_axis_second, box_axis_third
  input  logic [TdataBits-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // overlaps
  output logic [7:0]           m_axis_tdata
);
  logic [VecBits-1:0] ref_regs [NumRegs];
  token_t chain [NumAxes+1];
  logic stall;

  // Capture configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) ref_regs[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegRefCenter:  ref_regs[0] <= cfg_data;
        RegRefExtents: ref_regs[1] <= cfg_data;
        RegRefAxis0:   ref_regs[2] <= cfg_data;
        RegRefAxis1:   ref_regs[3] <= cfg_data;
        RegRefAxis2:   ref_regs[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign stall = chain[NumAxes].valid && !m_axis_tready;
  assign s_axis_tready = !stall;

  // Feed the first cell
  always_comb begin
    chain[0].valid = s_axis_tvalid;
    chain[0].apart = 1'b0;
    chain[0].a.center = unpack_vec(ref_regs[0]);
    chain[0].a.ext = unpack_vec(ref_regs[1]);
    for (int i = 0; i < 3; i++) chain[0].a.rows[i] = unpack_vec(ref_regs[2+i]);
    chain[0].b.center = unpack_vec(s_axis_tdata[VecBits-1:0]);
    chain[0].b.ext = unpack_vec(s_axis_tdata[2*VecBits-1:VecBits]);
    chain[0].b.rows[0] = unpack_vec(s_axis_tdata[3*VecBits-1:2*VecBits]);
    chain[0].b.rows[1] = unpack_vec(s_axis_tdata[4*VecBits-1:3*VecBits]);
    chain[0].b.rows[2] = unpack_vec(s_axis_tdata[5*VecBits-1:4*VecBits]);
  end

  // Face axes of the reference box, then of the tested box, then the crosses
  for (genvar g = 0; g < NumAxes; g++) begin : g_cell
    localparam axis_kind_t Kind = (g < 3) ? AxisFaceRef :
                                  ((g < 6) ? AxisFaceBox : AxisCross);
    localparam int RowA = (g < 3) ? g : ((g < 6) ? 0 : (g - 6) / 3);
    localparam int RowB = (g < 3) ? 0 : ((g < 6) ? g - 3 : (g - 6) % 3);
    obb_cell u_cell (
      .clk(clk), .rst(rst), .stall(stall), .kind(Kind),
      .row_a(2'(RowA)), .row_b(2'(RowB)),
      .tok_in(chain[g]), .tok_out(chain[g+1])
    );
  end

  assign m_axis_tvalid = chain[NumAxes].valid;
  assign m_axis_tdata = {7'd0, !chain[NumAxes].apart};
endmodule

// ----- hw/rtl/obb_checker.sv -----
`include "obb_overlap_separating_axis_macros.svh"
module obb_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);
  `OBB_ASSERT_IMP(a_ready_when_free, clk, rst, !m_axis_tvalid, s_axis_tready, "ready low while output free")
  `OBB_ASSERT_IMP(a_pad_zero, clk, rst, m_axis_tvalid, m_axis_tdata[7:1] == 7'd0, "pad bits set")
  `OBB_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
endmodule

bind obb_overlap_separating_axis obb_checker u_obb_checker (.*);

// ----- dv/tb_top.sv -----
module tb_top;
  import obb_pkg::*;

  // Wide signed arithmetic for exact projections
  typedef logic signed [191:0] acc_t;
  typedef logic signed [63:0] sc_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IdxBits-1:0] cfg_index = '0;
  logic [VecBits-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // box_center, box_extents, box_axis_first, box_axis_second, box_axis_third
  logic [TdataBits-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // overlaps
  logic [7:0] m_axis_tdata;

  obb_overlap_separating_axis u_dut (.*);

  always #5 clk = ~clk;

  logic [VecBits-1:0] ref_box [NumRegs];
  bit overlap_q[$];
  int fail_cnt = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_recv = 0;
  longint unsigned cycle_cnt = 0;

  function automatic sc_t comp_of(logic [VecBits-1:0] p, int k);
    logic signed [CompBits-1:0] c;
    c = p[k*CompBits +: CompBits];
    return sc_t'(c);
  endfunction

  function automatic acc_t dot_of(sc_t u[3], sc_t v[3]);
    return acc_t'(u[0]) * v[0] + acc_t'(u[1]) * v[1] + acc_t'(u[2]) * v[2];
  endfunction

  function automatic acc_t mag(acc_t x);
    return x < 0 ? -x : x;
  endfunction

  // Separating axis test over 15 candidate axes
  function automatic bit predict_overlap(logic [VecBits-1:0] bx [5]);
    sc_t ra[3][3], rb[3][3], ea[3], eb[3], df[3], ax[3];
    acc_t proj, rad;
    bit apart;
    apart = 0;
    for (int k = 0; k < 3; k++) begin
      ea[k] = comp_of(ref_box[1], k);
      eb[k] = comp_of(bx[1], k);
      df[k] = comp_of(bx[0], k) - comp_of(ref_box[0], k);
      for (int r = 0; r < 3; r++) begin
        ra[r][k] = comp_of(ref_box[2+r], k);
        rb[r][k] = comp_of(bx[2+r], k);
      end
    end
    for (int n = 0; n < NumAxes; n++) begin
      if (n < 3) ax = ra[n];
      else if (n < 6) ax = rb[n-3];
      else begin
        int i, j;
        i = (n - 6) / 3;
        j = (n - 6) % 3;
        ax[0] = rb[j][1] * ra[i][2] - rb[j][2] * ra[i][1];
        ax[1] = rb[j][2] * ra[i][0] - rb[j][0] * ra[i][2];
        ax[2] = rb[j][0] * ra[i][1] - rb[j][1] * ra[i][0];
        if (ax[0] == 0 && ax[1] == 0 && ax[2] == 0) continue;
      end
      proj = mag(dot_of(df, ax)) <<< FracBits;
      rad = 0;
      for (int k = 0; k < 3; k++)
        rad += mag(dot_of(ra[k], ax)) * ea[k] + mag(dot_of(rb[k], ax)) * eb[k];
      if (proj > rad) apart = 1;
    end
    return !apart;
  endfunction

  function automatic logic [VecBits-1:0] pack3(int x, int y, int z);
    logic [CompBits-1:0] cx, cy, cz;
    cx = CompBits'(x); cy = CompBits'(y); cz = CompBits'(z);
    return {cz, cy, cx};
  endfunction

  function automatic logic [VecBits-1:0] rnd_vec(int span);
    return pack3($urandom_range(2*span) - span, $urandom_range(2*span) - span,
                 $urandom_range(2*span) - span);
  endfunction

  function automatic logic [VecBits-1:0] wild_vec();
    return VecBits'({$urandom, $urandom});
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 3000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stall, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (overlap_q.size() == 0) begin
        $error("unexpected result overlaps=%0d", m_axis_tdata[0]);
        fail_cnt++;
      end else begin
        bit exp_ov;
        exp_ov = overlap_q.pop_front();
        if (m_axis_tdata[0] !== exp_ov || m_axis_tdata[7:1] !== '0) begin
          $error("overlaps: expected %0d actual %0d", exp_ov, m_axis_tdata);
          fail_cnt++;
        end
      end
    end
  end

  // Offer one request; valid stays high after acceptance until the next
  // idle cycle or the next drain
  task automatic send_box(logic [VecBits-1:0] b0, logic [VecBits-1:0] b1,
                          logic [VecBits-1:0] b2, logic [VecBits-1:0] b3,
                          logic [VecBits-1:0] b4);
    logic [VecBits-1:0] bx [5];
    bx = '{b0, b1, b2, b3, b4};
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, b4, b3, b2, b1, b0};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    overlap_q.push_back(predict_overlap(bx));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (overlap_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [IdxBits-1:0] idx, logic [VecBits-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    ref_box[idx] = val;
  endtask

  task automatic set_ref(logic [VecBits-1:0] c, logic [VecBits-1:0] e,
                         logic [VecBits-1:0] a0, logic [VecBits-1:0] a1,
                         logic [VecBits-1:0] a2);
    drain();
    write_reg(RegRefCenter, c);
    write_reg(RegRefExtents, e);
    write_reg(RegRefAxis0, a0);
    write_reg(RegRefAxis1, a1);
    write_reg(RegRefAxis2, a2);
    cfg_we <= 1'b0;
  endtask

  // Identity or random axes in Q.8 and a near box for well-formed tests
  task automatic send_near_box(int span, int axis_span);
    logic [VecBits-1:0] r0, r1, r2;
    if ($urandom_range(1)) begin
      r0 = pack3(256, 0, 0); r1 = pack3(0, 256, 0); r2 = pack3(0, 0, 256);
    end else begin
      r0 = rnd_vec(axis_span); r1 = rnd_vec(axis_span); r2 = rnd_vec(axis_span);
    end
    send_box(rnd_vec(span), pack3($urandom_range(span), $urandom_range(span),
             $urandom_range(span)), r0, r1, r2);
  endtask

  task automatic test_directed();
    logic [VecBits-1:0] idn0, idn1, idn2, mx, mn;
    idn0 = pack3(256, 0, 0); idn1 = pack3(0, 256, 0); idn2 = pack3(0, 0, 256);
    mx = pack3(1048575, 1048575, 1048575);
    mn = pack3(-1048576, -1048576, -1048576);
    // reset registers: all-zero reference box
    send_box('0, '0, '0, '0, '0);
    send_box({VecBits{1'b1}}, {VecBits{1'b1}}, {VecBits{1'b1}},
             {VecBits{1'b1}}, {VecBits{1'b1}});
    set_ref('0, pack3(512, 512, 512), idn0, idn1, idn2);
    // touching, overlapping and separated aligned boxes
    send_box(pack3(1024, 0, 0), pack3(512, 512, 512), idn0, idn1, idn2);
    send_box(pack3(1025, 0, 0), pack3(512, 512, 512), idn0, idn1, idn2);
    send_box(pack3(0, 0, 0), pack3(256, 256, 256), idn0, idn1, idn2);
    send_box(pack3(0, -2000, 0), pack3(256, 256, 256), idn0, idn1, idn2);
    // parallel rows skip cross axes; zero face rows never separate
    send_box(pack3(0, 0, 900), pack3(256, 256, 256), idn0, idn0, idn0);
    send_box(pack3(3000, 0, 0), pack3(256, 256, 256), '0, '0, '0);
    // rotated box: diagonal rows, cross axes matter
    send_box(pack3(1100, 1100, 0), pack3(256, 256, 256), pack3(181, 181, 0),
             pack3(-181, 181, 0), idn2);
    send_box(pack3(900, 900, 900), pack3(300, 300, 300), pack3(181, 181, 0),
             pack3(0, 181, 181), pack3(181, 0, 181));
    // negative extents shrink the radius
    send_box(pack3(600, 0, 0), pack3(-256, 256, 256), idn0, idn1, idn2);
    // component extremes and set high bit
    send_box(mx, mx, mx, mn, mx);
    send_box(mn, mn, mn, mx, mn);
    send_box(mx | {1'b1, 62'd0}, mn, idn0, idn1, idn2);
    set_ref(mx, mx, mx, mn, mx);
    send_box(mn, mx, mn, mx, mn);
    send_box(mx, mn, idn0, idn1, idn2);
    set_ref(mn, mn, mn, mx, {VecBits{1'b1}});
    send_box(mx, mx, mx, mx, mx);
    send_box(mn, mn, idn0, idn2, idn1);
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0)
        case ($urandom_range(3))
          0: set_ref(rnd_vec(2000), pack3($urandom_range(1500), $urandom_range(1500),
                     $urandom_range(1500)), pack3(256, 0, 0), pack3(0, 256, 0),
                     pack3(0, 0, 256));
          1: set_ref(rnd_vec(2000), pack3($urandom_range(1500), $urandom_range(1500),
                     $urandom_range(1500)), rnd_vec(300), rnd_vec(300), rnd_vec(300));
          2: set_ref(wild_vec(), wild_vec(), wild_vec(), wild_vec(), wild_vec());
          default: set_ref(rnd_vec(20), rnd_vec(20), rnd_vec(3), rnd_vec(3), rnd_vec(3));
        endcase
      if ($urandom_range(9) == 0)
        send_box(wild_vec(), wild_vec(), wild_vec(), wild_vec(), wild_vec());
      else
        send_near_box(3000, 300);
    end
  endtask

  // Hold the receiver off while the sender keeps pushing
  task automatic test_backpressure();
    fork
      begin
        hold_recv = 1;
        for (int c = 0; c < 300; c++) @(posedge clk);
        hold_recv = 0;
      end
      begin
        for (int n = 0; n < 120; n++) send_near_box(2000, 300);
        s_axis_tvalid <= 1'b0;
      end
    join
    @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < NumRegs; i++) ref_box[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle = 13; recv_idle = 68;
    test_directed();
    test_random(450);
    send_idle = 68; recv_idle = 13;
    test_random(450);
    send_idle = 0; recv_idle = 0;
    test_backpressure();
    test_random(500);
    drain();
    if (fail_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
